// File: sv/ycc2rgb_pkg.sv
`default_nettype none
package ycc2rgb_pkg;

   localparam int FRACTION_BITS_DEFAULT = 16;
   localparam int TERM_EXTRA_BITS = 10;

   localparam int LUMA_OFFSET = 16;
   localparam int LUMA_RANGE = 219;
   localparam int CHROMA_OFFSET = 128;
   localparam int CHROMA_RANGE = 224;
   localparam int FULL_SCALE = 255;

   localparam longint COEF_DEN = 100000;
   localparam longint COEF_R_V = 140200;
   localparam longint COEF_G_U = 34414;
   localparam longint COEF_G_V = 71414;
   localparam longint COEF_B_U = 177200;

   typedef struct packed {
      logic load_s1;
      logic load_s2;
      logic load_s3;
   } pipe_ctrl_type;

endpackage
`default_nettype wire

// File: sv/ycbcr_pair_to_rgb_clamped.sv
// Converts a pair of video-range BT.601 pixels that share one Cb and Cr sample into two
// clamped 8-bit RGB pixels, plus the mean of each pixel's three colors when gray mode is
// enabled (zero otherwise). The pipeline has three stages: constant-table lookup of the
// luma and chroma terms, sum with floor shift and clamp in two parallel pixel lanes, and
// the gray mean by reciprocal multiply. One item is accepted every cycle while the result
// side does not stall; each stage holds only while its successor is full, so bubbles are
// filled. gray_enable is sampled at the output, so it should only be written while the
// block is idle.
`default_nettype none
module ycbcr_pair_to_rgb_clamped #(
   parameter int FRACTION_BITS = ycc2rgb_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_gray_enable,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_luma_a,
   input  wire logic [7:0] req_luma_b,
   input  wire logic [7:0] req_chroma_blue,
   input  wire logic [7:0] req_chroma_red,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_red_a,
   output logic [7:0]      rsp_green_a,
   output logic [7:0]      rsp_blue_a,
   output logic [7:0]      rsp_red_b,
   output logic [7:0]      rsp_green_b,
   output logic [7:0]      rsp_blue_b,
   output logic [7:0]      rsp_gray_a,
   output logic [7:0]      rsp_gray_b
);

   localparam int TermW = FRACTION_BITS + ycc2rgb_pkg::TERM_EXTRA_BITS;

   ycc2rgb_pkg::pipe_ctrl_type ctrl;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic gray_enable_ff, gray_enable_in;
   logic signed [TermW-1:0] red_term, green_term, blue_term;
   logic [7:0] gray_a, gray_b;

   always_comb begin
      ctrl.load_s3 = !rsp_valid_ff || !rsp_stall;
      ctrl.load_s2 = !s2_valid_ff || ctrl.load_s3;
      ctrl.load_s1 = !s1_valid_ff || ctrl.load_s2;
      s1_valid_in  = ctrl.load_s1 ? req_valid : s1_valid_ff;
      s2_valid_in  = ctrl.load_s2 ? s1_valid_ff : s2_valid_ff;
      rsp_valid_in = ctrl.load_s3 ? s2_valid_ff : rsp_valid_ff;
      gray_enable_in = csr_write_enable ? csr_gray_enable : gray_enable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         gray_enable_ff <= 1'b0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         gray_enable_ff <= gray_enable_in;
      end
   end

   ycc2rgb_chroma #(.FRACTION_BITS(FRACTION_BITS)) u_chroma (
      .clock       (clock),
      .ctrl        (ctrl),
      .chroma_blue (req_chroma_blue),
      .chroma_red  (req_chroma_red),
      .red_term    (red_term),
      .green_term  (green_term),
      .blue_term   (blue_term)
   );

   ycc2rgb_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_a (
      .clock      (clock),
      .ctrl       (ctrl),
      .luma       (req_luma_a),
      .red_term   (red_term),
      .green_term (green_term),
      .blue_term  (blue_term),
      .red        (rsp_red_a),
      .green      (rsp_green_a),
      .blue       (rsp_blue_a),
      .gray       (gray_a)
   );

   ycc2rgb_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_b (
      .clock      (clock),
      .ctrl       (ctrl),
      .luma       (req_luma_b),
      .red_term   (red_term),
      .green_term (green_term),
      .blue_term  (blue_term),
      .red        (rsp_red_b),
      .green      (rsp_green_b),
      .blue       (rsp_blue_b),
      .gray       (gray_b)
   );

   assign req_stall  = !ctrl.load_s1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_gray_a = gray_enable_ff ? gray_a : 8'd0;
   assign rsp_gray_b = gray_enable_ff ? gray_b : 8'd0;

   // An accepted item always occupies the first stage on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted item missing from first stage");

   // A full pipeline with a stalled output must stall the input.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("input accepted while pipeline full");

   // In gray mode the first pixel's gray value is the floor of the mean of its three colors.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && gray_enable_ff) |->
         ((10'(rsp_gray_a) * 10'd3 <= 10'(rsp_red_a) + 10'(rsp_green_a) + 10'(rsp_blue_a))
          && (10'(rsp_red_a) + 10'(rsp_green_a) + 10'(rsp_blue_a)
              < 10'(rsp_gray_a) * 10'd3 + 10'd3)))
      else $error("gray mean of first pixel wrong");

endmodule
`default_nettype wire

// File: sv/ycc2rgb_chroma.sv
`default_nettype none
module ycc2rgb_chroma #(
   parameter int FRACTION_BITS = ycc2rgb_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire ycc2rgb_pkg::pipe_ctrl_type              ctrl,
   input  wire logic [7:0]                              chroma_blue,
   input  wire logic [7:0]                              chroma_red,
   output logic signed [FRACTION_BITS+ycc2rgb_pkg::TERM_EXTRA_BITS-1:0] red_term,
   output logic signed [FRACTION_BITS+ycc2rgb_pkg::TERM_EXTRA_BITS-1:0] green_term,
   output logic signed [FRACTION_BITS+ycc2rgb_pkg::TERM_EXTRA_BITS-1:0] blue_term
);

   localparam int TermW = FRACTION_BITS + ycc2rgb_pkg::TERM_EXTRA_BITS;
   localparam longint ChromaDen = ycc2rgb_pkg::COEF_DEN * longint'(ycc2rgb_pkg::CHROMA_RANGE);
   localparam longint ChromaDen2 = 2 * ChromaDen;

   typedef logic signed [TermW-1:0] term_table_type [256];

   // Each entry is the rounded Q-format chroma term for one 8-bit sample.
   function automatic term_table_type build_table(input longint coef);
      term_table_type t;
      longint num;
      for (int s = 0; s < 256; s++) begin
         num = longint'(s - ycc2rgb_pkg::CHROMA_OFFSET) * coef
               * longint'(ycc2rgb_pkg::FULL_SCALE) * (longint'(1) <<< FRACTION_BITS);
         t[s] = TermW'((2 * num + ChromaDen) / ChromaDen2);
      end
      return t;
   endfunction

   localparam term_table_type RvTable = build_table(ycc2rgb_pkg::COEF_R_V);
   localparam term_table_type GuTable = build_table(ycc2rgb_pkg::COEF_G_U);
   localparam term_table_type GvTable = build_table(ycc2rgb_pkg::COEF_G_V);
   localparam term_table_type BuTable = build_table(ycc2rgb_pkg::COEF_B_U);

   logic signed [TermW-1:0] red_term_ff, red_term_in;
   logic signed [TermW-1:0] green_term_ff, green_term_in;
   logic signed [TermW-1:0] blue_term_ff, blue_term_in;

   always_comb begin
      red_term_in   = RvTable[chroma_red];
      green_term_in = -GuTable[chroma_blue] - GvTable[chroma_red];
      blue_term_in  = BuTable[chroma_blue];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_s1) begin
         red_term_ff   <= red_term_in;
         green_term_ff <= green_term_in;
         blue_term_ff  <= blue_term_in;
      end
   end

   assign red_term   = red_term_ff;
   assign green_term = green_term_ff;
   assign blue_term  = blue_term_ff;

endmodule
`default_nettype wire

// File: sv/ycc2rgb_lane.sv
`default_nettype none
module ycc2rgb_lane #(
   parameter int FRACTION_BITS = ycc2rgb_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire ycc2rgb_pkg::pipe_ctrl_type              ctrl,
   input  wire logic [7:0]                              luma,
   input  wire logic signed [FRACTION_BITS+ycc2rgb_pkg::TERM_EXTRA_BITS-1:0] red_term,
   input  wire logic signed [FRACTION_BITS+ycc2rgb_pkg::TERM_EXTRA_BITS-1:0] green_term,
   input  wire logic signed [FRACTION_BITS+ycc2rgb_pkg::TERM_EXTRA_BITS-1:0] blue_term,
   output logic [7:0]                                   red,
   output logic [7:0]                                   green,
   output logic [7:0]                                   blue,
   output logic [7:0]                                   gray
);

   localparam int TermW = FRACTION_BITS + ycc2rgb_pkg::TERM_EXTRA_BITS;
   localparam int SumW = TermW + 1;
   localparam longint LumaDen2 = 2 * longint'(ycc2rgb_pkg::LUMA_RANGE);
   localparam longint LumaHalf = longint'(1) <<< (FRACTION_BITS - 1);
   localparam int ColorSumW = 10;
   localparam int GrayRecip = 683;
   localparam int GrayShift = 11;
   localparam int GrayProdW = ColorSumW + 10;

   typedef logic signed [TermW-1:0] term_table_type [256];

   // Luma term per sample, with the rounding half of the final shift folded in.
   function automatic term_table_type build_table();
      term_table_type t;
      longint num;
      for (int s = 0; s < 256; s++) begin
         num = longint'(s - ycc2rgb_pkg::LUMA_OFFSET) * longint'(ycc2rgb_pkg::FULL_SCALE)
               * (longint'(1) <<< FRACTION_BITS);
         t[s] = TermW'(LumaHalf + (2 * num + longint'(ycc2rgb_pkg::LUMA_RANGE)) / LumaDen2);
      end
      return t;
   endfunction

   localparam term_table_type LumaTable = build_table();

   function automatic logic [7:0] shift_clamp(input logic signed [SumW-1:0] s);
      logic signed [SumW-1:0] q;
      q = s >>> FRACTION_BITS;
      priority if (q < 0) begin
         return 8'd0;
      end else if (q > $signed(SumW'(255))) begin
         return 8'd255;
      end else begin
         return q[7:0];
      end
   endfunction

   logic signed [TermW-1:0] luma_term_ff;
   logic [7:0] red_s2_ff, green_s2_ff, blue_s2_ff;
   logic [7:0] red_s2_in, green_s2_in, blue_s2_in;
   logic [7:0] red_ff, green_ff, blue_ff, gray_ff, gray_in;
   logic [ColorSumW-1:0] color_sum;
   logic [GrayProdW-1:0] gray_prod;

   always_ff @(posedge clock) begin
      if (ctrl.load_s1) begin
         luma_term_ff <= LumaTable[luma];
      end
   end

   always_comb begin
      red_s2_in   = shift_clamp(SumW'(luma_term_ff) + SumW'(red_term));
      green_s2_in = shift_clamp(SumW'(luma_term_ff) + SumW'(green_term));
      blue_s2_in  = shift_clamp(SumW'(luma_term_ff) + SumW'(blue_term));
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_s2) begin
         red_s2_ff   <= red_s2_in;
         green_s2_ff <= green_s2_in;
         blue_s2_ff  <= blue_s2_in;
      end
   end

   // Division by three as a reciprocal multiply; exact for sums up to 765.
   always_comb begin
      color_sum = ColorSumW'(red_s2_ff) + ColorSumW'(green_s2_ff) + ColorSumW'(blue_s2_ff);
      gray_prod = GrayProdW'(color_sum) * GrayProdW'(GrayRecip);
      gray_in   = gray_prod[GrayShift+7:GrayShift];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_s3) begin
         red_ff   <= red_s2_ff;
         green_ff <= green_s2_ff;
         blue_ff  <= blue_s2_ff;
         gray_ff  <= gray_in;
      end
   end

   assign red   = red_ff;
   assign green = green_ff;
   assign blue  = blue_ff;
   assign gray  = gray_ff;

endmodule
`default_nettype wire

// File: test/ycbcr_pair_to_rgb_clamped_tb.sv
`timescale 1ns / 1ps
module ycbcr_pair_to_rgb_clamped_tb;

   localparam int FRAC = ycc2rgb_pkg::FRACTION_BITS_DEFAULT;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_PAIRS = 270;
   localparam int RANDOM_PHASES = 5;
   localparam int TAIL_PAIRS = 200;
   localparam int SETTLE_CYCLES = 6;

   typedef struct packed {
      logic [7:0] luma_a;
      logic [7:0] luma_b;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
   } pair_item_type;

   typedef struct packed {
      logic [7:0] red_a;
      logic [7:0] green_a;
      logic [7:0] blue_a;
      logic [7:0] red_b;
      logic [7:0] green_b;
      logic [7:0] blue_b;
      logic [7:0] gray_a;
      logic [7:0] gray_b;
   } rgb_pair_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic       csr_gray_enable = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_luma_a = 8'd0;
   logic [7:0] req_luma_b = 8'd0;
   logic [7:0] req_chroma_blue = 8'd0;
   logic [7:0] req_chroma_red = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_red_a;
   logic [7:0] rsp_green_a;
   logic [7:0] rsp_blue_a;
   logic [7:0] rsp_red_b;
   logic [7:0] rsp_green_b;
   logic [7:0] rsp_blue_b;
   logic [7:0] rsp_gray_a;
   logic [7:0] rsp_gray_b;

   pair_item_type pair_backlog[$];
   rgb_pair_type  rgb_due[$];
   bit         gray_mode = 1'b0;
   bit         tail_phase = 1'b0;
   bit         req_fire = 1'b0;
   int         fail_count = 0;
   int         idle_cycles = 0;
   int         sent_count = 0;
   int         done_count = 0;
   logic [31:0] tick = 0;
   int         gap_left = 0;
   int         send_odds = 0;
   int         stall_left = 0;
   int         stall_odds = 0;

   string field_names[8] = '{"red_a", "green_a", "blue_a", "red_b", "green_b", "blue_b",
                             "gray_a", "gray_b"};

   pair_item_type corner_pairs[12] = '{
      '{8'd16, 8'd235, 8'd128, 8'd128}, '{8'd0, 8'd255, 8'd128, 8'd128},
      '{8'd255, 8'd0, 8'd128, 8'd128}, '{8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd255, 8'd255, 8'd255, 8'd255}, '{8'd0, 8'd255, 8'd0, 8'd255},
      '{8'd255, 8'd0, 8'd255, 8'd0}, '{8'd16, 8'd16, 8'd16, 8'd16},
      '{8'd235, 8'd235, 8'd240, 8'd240}, '{8'd128, 8'd128, 8'd16, 8'd240},
      '{8'd128, 8'd128, 8'd240, 8'd16}, '{8'd1, 8'd254, 8'd127, 8'd129}
   };

   ycbcr_pair_to_rgb_clamped u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_gray_enable (csr_gray_enable),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_luma_a      (req_luma_a),
      .req_luma_b      (req_luma_b),
      .req_chroma_blue (req_chroma_blue),
      .req_chroma_red  (req_chroma_red),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red_a       (rsp_red_a),
      .rsp_green_a     (rsp_green_a),
      .rsp_blue_a      (rsp_blue_a),
      .rsp_red_b       (rsp_red_b),
      .rsp_green_b     (rsp_green_b),
      .rsp_blue_b      (rsp_blue_b),
      .rsp_gray_a      (rsp_gray_a),
      .rsp_gray_b      (rsp_gray_b)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Chroma contribution in Q format, rounded by adding half and truncating toward zero.
   function automatic longint chroma_share(input logic [7:0] sample, input longint coef);
      longint num;
      longint den;
      num = longint'(int'(sample) - ycc2rgb_pkg::CHROMA_OFFSET) * coef
            * ycc2rgb_pkg::FULL_SCALE * (longint'(1) << FRAC);
      den = ycc2rgb_pkg::COEF_DEN * ycc2rgb_pkg::CHROMA_RANGE;
      return (2 * num + den) / (2 * den);
   endfunction

   function automatic longint luma_share(input logic [7:0] sample);
      longint num;
      num = longint'(int'(sample) - ycc2rgb_pkg::LUMA_OFFSET) * ycc2rgb_pkg::FULL_SCALE
            * (longint'(1) << FRAC);
      return (longint'(1) << (FRAC - 1))
             + (2 * num + ycc2rgb_pkg::LUMA_RANGE) / (2 * ycc2rgb_pkg::LUMA_RANGE);
   endfunction

   function automatic logic [7:0] floor_clamp(input longint total);
      longint q;
      q = total >>> FRAC;
      if (q > 255) q = 255;
      if (q < 0) q = 0;
      return q[7:0];
   endfunction

   function automatic rgb_pair_type convert_pair(input pair_item_type item, input bit gray_on);
      rgb_pair_type px;
      longint    red_v;
      longint    green_uv;
      longint    blue_u;
      longint    ya;
      longint    yb;
      red_v = chroma_share(item.chroma_red, ycc2rgb_pkg::COEF_R_V);
      green_uv = -chroma_share(item.chroma_blue, ycc2rgb_pkg::COEF_G_U)
                 - chroma_share(item.chroma_red, ycc2rgb_pkg::COEF_G_V);
      blue_u = chroma_share(item.chroma_blue, ycc2rgb_pkg::COEF_B_U);
      ya = luma_share(item.luma_a);
      yb = luma_share(item.luma_b);
      px.red_a = floor_clamp(ya + red_v);
      px.green_a = floor_clamp(ya + green_uv);
      px.blue_a = floor_clamp(ya + blue_u);
      px.red_b = floor_clamp(yb + red_v);
      px.green_b = floor_clamp(yb + green_uv);
      px.blue_b = floor_clamp(yb + blue_u);
      px.gray_a = gray_on ? 8'((int'(px.red_a) + int'(px.green_a) + int'(px.blue_a)) / 3) : 8'd0;
      px.gray_b = gray_on ? 8'((int'(px.red_b) + int'(px.green_b) + int'(px.blue_b)) / 3) : 8'd0;
      return px;
   endfunction

   function automatic logic [7:0] random_sample();
      logic [7:0] edges[10] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd235, 8'd236, 8'd240, 8'd241,
                                8'd254, 8'd255};
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) return 8'($urandom);
      if (pick < 9) return 8'($urandom_range(16, 240));
      return edges[$urandom_range(0, 9)];
   endfunction

   function automatic bit quiet_tail();
      return tail_phase && pair_backlog.size() < TAIL_PAIRS;
   endfunction

   always @(posedge clock) begin
      tick <= tick + 1;
      req_fire <= req_valid && !req_stall;
   end

   always @(negedge clock) begin
      if (tick[5:0] == 6'd0) send_odds = $urandom_range(0, 4);
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (pair_backlog.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!quiet_tail() && send_odds != 0 && $urandom_range(1, 12) <= send_odds) begin
            gap_left = $urandom_range(0, 7);
            req_valid <= 1'b0;
         end else begin
            {req_luma_a, req_luma_b, req_chroma_blue, req_chroma_red} <= pair_backlog.pop_front();
            sent_count = sent_count + 1;
            req_valid <= 1'b1;
         end
      end
   end

   always @(negedge clock) begin
      if (tick[5:0] == 6'd32) stall_odds = $urandom_range(0, 4);
      if (reset || quiet_tail()) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_odds != 0 && $urandom_range(1, 12) <= stall_odds) begin
         stall_left = $urandom_range(0, 7);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_results
      rgb_pair_type want;
      rgb_pair_type seen;
      int        i;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            rgb_due.push_back(convert_pair({req_luma_a, req_luma_b, req_chroma_blue,
                                            req_chroma_red}, gray_mode));
         end
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_red_a, rsp_green_a, rsp_blue_a, rsp_red_b, rsp_green_b, rsp_blue_b,
                    rsp_gray_a, rsp_gray_b};
            if (rgb_due.size() == 0) begin
               $error("result arrived with no item outstanding");
               fail_count++;
            end else begin
               want = rgb_due.pop_front();
               done_count = done_count + 1;
               for (i = 0; i < 8; i++) begin
                  if (seen[63 - 8 * i -: 8] !== want[63 - 8 * i -: 8]) begin
                     $error("%s: expected %0d, got %0d", field_names[i],
                            want[63 - 8 * i -: 8], seen[63 - 8 * i -: 8]);
                     fail_count++;
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic drain_results();
      while (pair_backlog.size() != 0 || sent_count != done_count) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_gray(input bit value);
      csr_write_enable <= 1'b1;
      csr_gray_enable <= value;
      gray_mode = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic queue_corner_pairs();
      foreach (corner_pairs[i]) pair_backlog.push_back(corner_pairs[i]);
   endtask

   initial begin
      int phase;
      int n;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Corner items first with the reset setting, then again with gray mode on.
      queue_corner_pairs();
      drain_results();
      write_gray(1'b1);
      queue_corner_pairs();
      drain_results();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_gray(phase[0]);
         if (phase == RANDOM_PHASES - 1) tail_phase = 1'b1;
         for (n = 0; n < PHASE_PAIRS; n++) begin
            pair_backlog.push_back({random_sample(), random_sample(), random_sample(),
                                    random_sample()});
         end
         drain_results();
      end

      if (rgb_due.size() != 0) begin
         $error("%0d results never arrived", rgb_due.size());
      end
      if (fail_count == 0 && rgb_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
